// ===== src/kwsc_pkg.sv =====
package kwsc_pkg;

    localparam int unsigned ALPHA_COUNT = 26;
    localparam int unsigned LETTER_W    = 5;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned BYTE_W      = 8;

    localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHA_COUNT - 1);
    localparam logic [COUNT_W-1:0]  FULL_COUNT  = COUNT_W'(ALPHA_COUNT);

    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_KEY  = 3'b010,
        ST_FILL = 3'b100
    } state_t;

endpackage

// ===== src/kwsc_ram.sv =====
module kwsc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/keyword_substitution_cipher_unit.sv =====
// Channel | Direction | Signals                                   | Word
// --------+-----------+-------------------------------------------+-----------------------------
// input   | in        | in_valid, in_ready                        | operation, key_start, in_byte
// output  | out       | out_valid, out_ready                      | out_byte, key_error
// config  | in        | cfg_valid, cfg_ready                      | direction
//
// A keyword word needs no table lookup; a data word with built tables is accepted, read from the
// table RAM into its read register, and then passes to the output register.
// The first data word after a valid keyword waits for the table build, which is paced by the
// single read port of the keyword RAM and at most one table write per cycle.
// Reset clears all control state; the tables are built before any read, so no clearing pass.
// A stalled output holds the result and one lookup in flight, then drops in_ready.
module keyword_substitution_cipher_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic       key_start,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       key_error,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       direction
);

    kwsc_pkg::state_t state_reg, state_next;

    logic [kwsc_pkg::ALPHA_COUNT-1:0] used_reg, used_next;
    logic [kwsc_pkg::COUNT_W-1:0]     key_length_reg, key_length_next;
    logic                             key_invalid_reg, key_invalid_next;
    logic                             tables_ready_reg, tables_ready_next;
    logic                             direction_reg, direction_next;

    logic [kwsc_pkg::COUNT_W-1:0]     key_idx_reg, key_idx_next;
    logic                             key_vld_reg, key_vld_next;
    logic [kwsc_pkg::COUNT_W-1:0]     pos_reg, pos_next;
    logic [kwsc_pkg::LETTER_W-1:0]    fill_reg, fill_next;

    logic                             s1_valid_reg, s1_valid_next;
    logic                             s1_err_reg;
    logic                             s1_letter_reg;
    logic                             s1_lower_reg;
    logic [kwsc_pkg::BYTE_W-1:0]      s1_byte_reg;

    logic                             out_valid_reg, out_valid_next;
    logic [kwsc_pkg::BYTE_W-1:0]      out_byte_reg, out_byte_next;
    logic                             out_err_reg, out_err_next;

    logic                             is_upper, is_lower, is_letter;
    logic [kwsc_pkg::LETTER_W-1:0]    in_idx;
    logic                             data_err;
    logic                             build_req;
    logic                             s1_move;
    logic                             in_acc;
    logic                             key_acc;
    logic                             data_acc;

    logic [kwsc_pkg::ALPHA_COUNT-1:0] base_used;
    logic [kwsc_pkg::COUNT_W-1:0]     base_length;
    logic                             base_invalid;
    logic                             key_wr_en;
    logic                             key_rd_en;
    logic [kwsc_pkg::LETTER_W-1:0]    key_rd_data;

    logic                             tab_wr_en;
    logic [kwsc_pkg::LETTER_W-1:0]    tab_letter;
    logic                             look_en;
    logic [kwsc_pkg::LETTER_W-1:0]    fwd_rd_data;
    logic [kwsc_pkg::LETTER_W-1:0]    inv_rd_data;
    logic [kwsc_pkg::LETTER_W-1:0]    mapped;
    logic [kwsc_pkg::BYTE_W-1:0]      case_base;

    assign is_upper  = (in_byte >= kwsc_pkg::CHAR_UPPER_A) && (in_byte <= kwsc_pkg::CHAR_UPPER_Z);
    assign is_lower  = (in_byte >= kwsc_pkg::CHAR_LOWER_A) && (in_byte <= kwsc_pkg::CHAR_LOWER_Z);
    assign is_letter = is_upper || is_lower;
    assign in_idx    = is_upper ? kwsc_pkg::LETTER_W'(in_byte - kwsc_pkg::CHAR_UPPER_A)
                     : (is_lower ? kwsc_pkg::LETTER_W'(in_byte - kwsc_pkg::CHAR_LOWER_A)
                                 : '0);

    assign data_err  = key_invalid_reg || (key_length_reg == '0);
    assign build_req = in_valid && (operation == kwsc_pkg::OP_DATA) && !tables_ready_reg
                    && !data_err;
    assign s1_move   = s1_valid_reg && (!out_valid_reg || out_ready);

    assign in_ready  = (state_reg == kwsc_pkg::ST_IDLE) && (!s1_valid_reg || s1_move)
                    && !build_req;
    assign in_acc    = in_valid && in_ready;
    assign key_acc   = in_acc && (operation == kwsc_pkg::OP_KEY);
    assign data_acc  = in_acc && (operation == kwsc_pkg::OP_DATA);
    assign cfg_ready = 1'b1;

    assign base_used    = key_start ? '0 : used_reg;
    assign base_length  = key_start ? '0 : key_length_reg;
    assign base_invalid = key_start ? 1'b0 : key_invalid_reg;
    assign key_wr_en    = key_acc && is_letter && !base_used[in_idx]
                       && (base_length < kwsc_pkg::FULL_COUNT);

    assign key_rd_en  = (state_reg == kwsc_pkg::ST_KEY) && (key_idx_reg < key_length_reg);
    assign tab_letter = (state_reg == kwsc_pkg::ST_KEY) ? key_rd_data : fill_reg;
    assign tab_wr_en  = ((state_reg == kwsc_pkg::ST_KEY) && key_vld_reg)
                     || ((state_reg == kwsc_pkg::ST_FILL) && !used_reg[fill_reg]);
    assign look_en    = data_acc && is_letter && !data_err;

    kwsc_ram #(
        .WIDTH (kwsc_pkg::LETTER_W),
        .DEPTH (kwsc_pkg::ALPHA_COUNT)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (base_length),
        .wr_data (in_idx),
        .rd_en   (key_rd_en),
        .rd_addr (key_idx_reg),
        .rd_data (key_rd_data)
    );

    kwsc_ram #(
        .WIDTH (kwsc_pkg::LETTER_W),
        .DEPTH (kwsc_pkg::ALPHA_COUNT)
    ) u_fwd_ram (
        .clk     (clk),
        .wr_en   (tab_wr_en),
        .wr_addr (pos_reg),
        .wr_data (tab_letter),
        .rd_en   (look_en),
        .rd_addr (in_idx),
        .rd_data (fwd_rd_data)
    );

    kwsc_ram #(
        .WIDTH (kwsc_pkg::LETTER_W),
        .DEPTH (kwsc_pkg::ALPHA_COUNT)
    ) u_inv_ram (
        .clk     (clk),
        .wr_en   (tab_wr_en),
        .wr_addr (tab_letter),
        .wr_data (pos_reg),
        .rd_en   (look_en),
        .rd_addr (in_idx),
        .rd_data (inv_rd_data)
    );

    always_comb
    begin
        state_next        = state_reg;
        used_next         = used_reg;
        key_length_next   = key_length_reg;
        key_invalid_next  = key_invalid_reg;
        tables_ready_next = tables_ready_reg;
        direction_next    = direction_reg;
        key_idx_next      = key_idx_reg;
        key_vld_next      = key_rd_en;
        pos_next          = pos_reg;
        fill_next         = fill_reg;

        if (cfg_valid && cfg_ready)
        begin
            direction_next = direction;
        end

        // append keyword letter, or mark the keyword invalid on a non-letter
        if (key_acc)
        begin
            used_next         = base_used;
            key_length_next   = base_length;
            key_invalid_next  = base_invalid;
            tables_ready_next = 1'b0;
            if (is_letter)
            begin
                used_next = base_used
                          | (kwsc_pkg::ALPHA_COUNT'(1) << in_idx);
                if (key_wr_en)
                begin
                    key_length_next = base_length + 1'b1;
                end
            end
            else
            begin
                key_invalid_next = 1'b1;
            end
        end

        if (data_acc && !tables_ready_reg)
        begin
            key_invalid_next  = data_err;
            tables_ready_next = 1'b1;
        end

        if (tab_wr_en)
        begin
            pos_next = pos_reg + 1'b1;
        end

        unique case (state_reg)
            kwsc_pkg::ST_IDLE:
            begin
                if (build_req)
                begin
                    state_next   = kwsc_pkg::ST_KEY;
                    key_idx_next = '0;
                    pos_next     = '0;
                end
            end
            kwsc_pkg::ST_KEY:
            begin
                if (key_idx_reg == key_length_reg)
                begin
                    state_next = kwsc_pkg::ST_FILL;
                    fill_next  = kwsc_pkg::LAST_LETTER;
                end
                else
                begin
                    key_idx_next = key_idx_reg + 1'b1;
                end
            end
            kwsc_pkg::ST_FILL:
            begin
                if (fill_reg == '0)
                begin
                    state_next        = kwsc_pkg::ST_IDLE;
                    tables_ready_next = 1'b1;
                end
                else
                begin
                    fill_next = fill_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = kwsc_pkg::ST_IDLE;
            end
        endcase
    end

    assign mapped    = (direction_reg == kwsc_pkg::DIR_DECRYPT) ? inv_rd_data : fwd_rd_data;
    assign case_base = s1_lower_reg ? kwsc_pkg::CHAR_LOWER_A : kwsc_pkg::CHAR_UPPER_A;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_err_next   = out_err_reg;

        if (s1_move)
        begin
            s1_valid_next  = 1'b0;
            out_valid_next = 1'b1;
            if (s1_err_reg)
            begin
                out_byte_next = '0;
                out_err_next  = 1'b1;
            end
            else if (s1_letter_reg)
            begin
                out_byte_next = {3'b000, mapped} + case_base;
                out_err_next  = 1'b0;
            end
            else
            begin
                out_byte_next = s1_byte_reg;
                out_err_next  = 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (data_acc)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= kwsc_pkg::ST_IDLE;
            used_reg         <= '0;
            key_length_reg   <= '0;
            key_invalid_reg  <= 1'b1;
            tables_ready_reg <= 1'b0;
            direction_reg    <= kwsc_pkg::DIR_ENCRYPT;
            key_idx_reg      <= '0;
            key_vld_reg      <= 1'b0;
            pos_reg          <= '0;
            fill_reg         <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            used_reg         <= used_next;
            key_length_reg   <= key_length_next;
            key_invalid_reg  <= key_invalid_next;
            tables_ready_reg <= tables_ready_next;
            direction_reg    <= direction_next;
            key_idx_reg      <= key_idx_next;
            key_vld_reg      <= key_vld_next;
            pos_reg          <= pos_next;
            fill_reg         <= fill_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_acc)
        begin
            s1_err_reg    <= data_err;
            s1_letter_reg <= is_letter;
            s1_lower_reg  <= is_lower;
            s1_byte_reg   <= in_byte;
        end
        out_byte_reg <= out_byte_next;
        out_err_reg  <= out_err_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign key_error = out_err_reg;

`ifndef ASSERT_OFF
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != kwsc_pkg::ST_IDLE) |-> !in_ready)
        else $error("input accepted during table build");

    a_build_fills_all: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kwsc_pkg::ST_FILL) && (fill_reg == '0)
        |=> (pos_reg == kwsc_pkg::FULL_COUNT) && tables_ready_reg)
        else $error("table build did not cover the alphabet");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tab_wr_en |-> (pos_reg < kwsc_pkg::FULL_COUNT))
        else $error("table write beyond last position");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && key_error) |-> (out_byte == '0))
        else $error("error word carries a byte");

    a_lookup_ready: assert property (@(posedge clk) disable iff (!rst_n)
        look_en |-> tables_ready_reg)
        else $error("lookup before tables built");
`endif

endmodule
